FILE: hdl/csm_pkg.sv
// ============================================================================
// csm_pkg
// shared types, codes and digit helpers for the clock setter display block
// ============================================================================
package csm_pkg;

   typedef logic [2:0]  func_type;
   typedef logic [4:0]  hour_type;
   typedef logic [5:0]  minsec_type;
   typedef logic [1:0]  mode_type;
   typedef logic [6:0]  seg_type;
   typedef logic [5:0]  digit_sel_type;
   typedef logic [3:0]  bcd_type;
   typedef logic [2:0]  scan_idx_type;
   typedef logic [15:0] blink_cnt_type;
   typedef logic [7:0]  dwell_cnt_type;
   typedef logic [15:0] csr_data_type;
   typedef logic        csr_index_type;

   // transaction codes
   localparam func_type FUNC_TICK = 3'd0;
   localparam func_type FUNC_MODE = 3'd1;
   localparam func_type FUNC_UP   = 3'd2;
   localparam func_type FUNC_DOWN = 3'd3;
   localparam func_type FUNC_LOAD = 3'd4;

   // set modes
   localparam mode_type MODE_NORMAL = 2'd0;
   localparam mode_type MODE_HOUR   = 2'd1;
   localparam mode_type MODE_MINUTE = 2'd2;
   localparam mode_type MODE_SECOND = 2'd3;

   // register indexes
   localparam csr_index_type CSR_BLINK_HALF_PERIOD = 1'b0;
   localparam csr_index_type CSR_SCAN_DWELL        = 1'b1;

   localparam blink_cnt_type BLINK_RESET = 16'd1000;
   localparam dwell_cnt_type DWELL_RESET = 8'd1;

   localparam hour_type   HOUR_MAX   = 5'd23;
   localparam minsec_type MINSEC_MAX = 6'd59;
   localparam scan_idx_type SCAN_LAST = 3'd5;
   localparam seg_type    SEG_BLANK  = 7'h7F;

   // common-anode glyphs, active low a..g
   localparam logic [7:0] GLYPH [10] = '{
      8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
   };

   function automatic bcd_type tens_of(minsec_type v);
      bcd_type t;
      if (v >= 6'd60)      t = 4'd6;
      else if (v >= 6'd50) t = 4'd5;
      else if (v >= 6'd40) t = 4'd4;
      else if (v >= 6'd30) t = 4'd3;
      else if (v >= 6'd20) t = 4'd2;
      else if (v >= 6'd10) t = 4'd1;
      else                 t = 4'd0;
      return t;
   endfunction

   function automatic bcd_type units_of(minsec_type v);
      minsec_type t;
      minsec_type r;
      t = {2'b00, tens_of(v)};
      r = v - ((t << 3) + (t << 1));
      return r[3:0];
   endfunction

   function automatic seg_type glyph_of(bcd_type d);
      logic [7:0] g;
      g = (d <= 4'd9) ? GLYPH[d] : 8'hFF;
      return g[6:0];
   endfunction

   function automatic minsec_type wrap_up(minsec_type v, minsec_type limit);
      return (v + 6'd1 >= limit) ? 6'd0 : v + 6'd1;
   endfunction

   function automatic minsec_type wrap_down(minsec_type v, minsec_type limit);
      return (v == 6'd0 || v >= limit) ? limit - 6'd1 : v - 6'd1;
   endfunction

endpackage

FILE: hdl/csm_if.sv
// ============================================================================
// csm request and response channels
// valid/ready channels carrying one transaction each
// ============================================================================
interface csm_req_if;
   import csm_pkg::*;

   logic       valid;
   logic       ready;
   func_type   func;
   hour_type   load_hours;
   minsec_type load_minutes;
   minsec_type load_seconds;

   modport source (output valid, func, load_hours, load_minutes, load_seconds,
                   input ready);
   modport sink   (input valid, func, load_hours, load_minutes, load_seconds,
                   output ready);
endinterface

interface csm_rsp_if;
   import csm_pkg::*;

   logic          valid;
   logic          ready;
   seg_type       segments;
   digit_sel_type digit_select;
   hour_type      hours;
   minsec_type    minutes;
   minsec_type    seconds;
   mode_type      set_mode;
   logic          write_back;

   modport source (output valid, segments, digit_select, hours, minutes, seconds,
                   set_mode, write_back, input ready);
   modport sink   (input valid, segments, digit_select, hours, minutes, seconds,
                   set_mode, write_back, output ready);
endinterface

FILE: hdl/clock_setter_seven_segment_mux_top.sv
// ============================================================================
// clock_setter_seven_segment_mux_top
// time keeping with set mode, blink and six-digit seven-segment scan
// ============================================================================
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  req     | in  | valid/ready        | func, load_hours/minutes/seconds
//  rsp     | out | valid/ready        | segments, digit_select, time, mode,
//          |     |                    | write_back
//  csr     | in  | csr_write_en       | csr_index, csr_wdata
//
//  a request passes the input register, then the update logic into the
//  response register, before its response is valid; a stall on the
//  response can hold the request in the input register
//  one transaction per cycle sustained while the response is taken; the
//  state registers close a loop through the update logic
//  reset (synchronous) clears time, mode, timers and both valid flags
//  a stalled response holds the pipe; the input register still takes one
//  transaction while the response waits
//
module clock_setter_seven_segment_mux_top (
   input  logic                   clock,
   input  logic                   reset,
   csm_req_if.sink                req,
   csm_rsp_if.source              rsp,
   input  logic                   csr_write_en,
   input  csm_pkg::csr_index_type csr_index,
   input  csm_pkg::csr_data_type  csr_wdata
);
   import csm_pkg::*;

   // config registers
   blink_cnt_type blink_period_ff;
   dwell_cnt_type dwell_ff;

   // input register
   logic       in_valid_ff;
   func_type   in_func_ff;
   hour_type   in_hours_ff;
   minsec_type in_minutes_ff;
   minsec_type in_seconds_ff;

   // block state
   hour_type      hour_ff,        hour_in;
   minsec_type    minute_ff,      minute_in;
   minsec_type    second_ff,      second_in;
   mode_type      mode_ff,        mode_in;
   logic          blink_on_ff,    blink_on_in;
   blink_cnt_type blink_timer_ff, blink_timer_in;
   scan_idx_type  scan_idx_ff,    scan_idx_in;
   dwell_cnt_type scan_timer_ff,  scan_timer_in;

   // response register
   logic          out_valid_ff;
   seg_type       out_seg_ff,   out_seg_in;
   digit_sel_type out_dsel_ff,  out_dsel_in;
   logic          out_wb_ff,    out_wb_in;

   logic          advance;
   blink_cnt_type blink_plus;
   dwell_cnt_type scan_plus;
   logic [1:0]    pair;
   minsec_type    pair_val;
   bcd_type       digit;

   // response slot frees when empty or being taken
   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         blink_period_ff <= BLINK_RESET;
         dwell_ff        <= DWELL_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_BLINK_HALF_PERIOD: blink_period_ff <= csr_wdata;
            CSR_SCAN_DWELL:        dwell_ff        <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_func_ff    <= req.func;
         in_hours_ff   <= req.load_hours;
         in_minutes_ff <= req.load_minutes;
         in_seconds_ff <= req.load_seconds;
      end
   end

   // state update for the transaction in the input register
   always_comb begin
      hour_in        = hour_ff;
      minute_in      = minute_ff;
      second_in      = second_ff;
      mode_in        = mode_ff;
      blink_on_in    = blink_on_ff;
      blink_timer_in = blink_timer_ff;
      scan_idx_in    = scan_idx_ff;
      scan_timer_in  = scan_timer_ff;
      out_wb_in      = 1'b0;
      blink_plus     = blink_timer_ff + 16'd1;
      scan_plus      = scan_timer_ff + 8'd1;

      case (in_func_ff)
         FUNC_TICK: begin
            // period of zero behaves as one through the compare
            if (blink_plus >= blink_period_ff) begin
               blink_on_in    = !blink_on_ff;
               blink_timer_in = '0;
            end else begin
               blink_timer_in = blink_plus;
            end
            if (scan_plus >= dwell_ff) begin
               scan_idx_in   = (scan_idx_ff >= SCAN_LAST) ? 3'd0 : scan_idx_ff + 3'd1;
               scan_timer_in = '0;
            end else begin
               scan_timer_in = scan_plus;
            end
         end
         FUNC_MODE: mode_in = mode_ff + 2'd1;
         FUNC_UP, FUNC_DOWN: begin
            out_wb_in = (mode_ff != MODE_NORMAL);
            case (mode_ff)
               MODE_HOUR: begin
                  hour_in = (in_func_ff == FUNC_UP)
                     ? hour_type'(wrap_up({1'b0, hour_ff}, 6'd24))
                     : hour_type'(wrap_down({1'b0, hour_ff}, 6'd24));
               end
               MODE_MINUTE: begin
                  minute_in = (in_func_ff == FUNC_UP) ? wrap_up(minute_ff, 6'd60)
                                                      : wrap_down(minute_ff, 6'd60);
               end
               MODE_SECOND: begin
                  // seconds wrap down from zero to 59, as minutes do
                  second_in = (in_func_ff == FUNC_UP) ? wrap_up(second_ff, 6'd60)
                                                      : wrap_down(second_ff, 6'd60);
               end
               default: ;
            endcase
         end
         FUNC_LOAD: begin
            // clamp out-of-range rtc values
            hour_in   = (in_hours_ff > HOUR_MAX) ? HOUR_MAX : in_hours_ff;
            minute_in = (in_minutes_ff > MINSEC_MAX) ? MINSEC_MAX : in_minutes_ff;
            second_in = (in_seconds_ff > MINSEC_MAX) ? MINSEC_MAX : in_seconds_ff;
         end
         default: ;  // unused codes leave state alone
      endcase

      // display of the digit under the scan after the update
      pair = scan_idx_in[2:1];
      case (pair)
         2'd0:    pair_val = {1'b0, hour_in};
         2'd1:    pair_val = minute_in;
         default: pair_val = second_in;
      endcase
      digit       = scan_idx_in[0] ? units_of(pair_val) : tens_of(pair_val);
      out_dsel_in = digit_sel_type'(6'd1 << scan_idx_in);
      // selected pair blanks while blink is off
      if (mode_in == pair + 2'd1 && !blink_on_in) begin
         out_seg_in = SEG_BLANK;
      end else begin
         out_seg_in = glyph_of(digit);
      end
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         hour_ff        <= '0;
         minute_ff      <= '0;
         second_ff      <= '0;
         mode_ff        <= MODE_NORMAL;
         blink_on_ff    <= 1'b1;
         blink_timer_ff <= '0;
         scan_idx_ff    <= '0;
         scan_timer_ff  <= '0;
         out_valid_ff   <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            hour_ff        <= hour_in;
            minute_ff      <= minute_in;
            second_ff      <= second_in;
            mode_ff        <= mode_in;
            blink_on_ff    <= blink_on_in;
            blink_timer_ff <= blink_timer_in;
            scan_idx_ff    <= scan_idx_in;
            scan_timer_ff  <= scan_timer_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_seg_ff  <= out_seg_in;
         out_dsel_ff <= out_dsel_in;
         out_wb_ff   <= out_wb_in;
      end
   end

   // time and mode fields read straight from the state, which only moves
   // together with the response register
   assign rsp.valid        = out_valid_ff;
   assign rsp.segments     = out_seg_ff;
   assign rsp.digit_select = out_dsel_ff;
   assign rsp.hours        = hour_ff;
   assign rsp.minutes      = minute_ff;
   assign rsp.seconds      = second_ff;
   assign rsp.set_mode     = mode_ff;
   assign rsp.write_back   = out_wb_ff;

   // checks
   a_dsel_onehot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot(out_dsel_ff))
      else $error("digit select not one-hot");

   a_wb_needs_mode: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_wb_ff |-> mode_ff != MODE_NORMAL)
      else $error("write-back flagged in normal mode");

   a_time_range: assert property (@(posedge clock) disable iff (reset)
      hour_ff <= HOUR_MAX && minute_ff <= MINSEC_MAX && second_ff <= MINSEC_MAX
      && scan_idx_ff <= SCAN_LAST)
      else $error("time or scan index out of range");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(hour_ff))
      else $error("transaction lost or state moved during stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !out_valid_ff && !in_valid_ff)
      else $error("pipe not empty after reset");

endmodule
